// ===== rtl/core/hpw_pkg.sv =====
`default_nettype none

package hpw_pkg;

  localparam int unsigned COORD_BITS_DEF     = 16;
  localparam int unsigned COEF_FRAC_BITS_DEF = 16;
  localparam int unsigned PERSP_FRAC_BITS    = 30;
  localparam int unsigned CFG_IDX_W          = 4;
  localparam int unsigned CFG_DATA_W         = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCALE_XX   = 4'd0,
    REG_SHEAR_XY   = 4'd1,
    REG_SHIFT_X    = 4'd2,
    REG_SHEAR_YX   = 4'd3,
    REG_SCALE_YY   = 4'd4,
    REG_SHIFT_Y    = 4'd5,
    REG_PERSP_PAIR = 4'd6,
    REG_PERSP_BIAS = 4'd7
  } cfg_reg_e;

  // Per-point flags that ride along the pipeline next to the magnitudes.
  typedef struct packed {
    logic sn_x;   // numerator x negative
    logic sn_y;   // numerator y negative
    logic sd;     // denominator negative
    logic dz;     // denominator zero
    logic zx;     // numerator x zero
    logic zy;     // numerator y zero
    logic ovf_x;  // quotient x surely beyond the coordinate range
    logic ovf_y;  // quotient y surely beyond the coordinate range
  } side_t;

endpackage

`default_nettype wire

// ===== rtl/core/hpw_divider.sv =====
`default_nettype none

// Restoring divider, one quotient bit per register stage. The caller
// guarantees num < den << (COORD_BITS+1), so COORD_BITS+1 bits suffice.
module hpw_divider #(
  parameter int unsigned COORD_BITS = 16,
  parameter int unsigned NUM_W      = 64
) (
  input  wire logic                  clk_i,
  input  wire logic [COORD_BITS:0]   en_i,
  input  wire logic [NUM_W-1:0]      num_i,
  input  wire logic [NUM_W-1:0]      den_i,
  output logic      [COORD_BITS:0]   quo_o,
  output logic      [NUM_W-1:0]      rem_o,
  output logic      [NUM_W-1:0]      den_o
);

  localparam int unsigned STEPS = COORD_BITS + 1;
  localparam int unsigned UW    = NUM_W + STEPS;

  logic [UW-1:0]    rem_q [STEPS];
  logic [NUM_W-1:0] den_q [STEPS];
  logic [STEPS-1:0] quo_q [STEPS];

  for (genvar s = 0; s < STEPS; s++) begin : g_step
    localparam int unsigned Bit = STEPS - 1 - s;
    logic [UW-1:0]    r_in;
    logic [UW-1:0]    d_sh;
    logic [NUM_W-1:0] d_in;
    logic [STEPS-1:0] q_in;

    if (s == 0) begin : g_first
      assign r_in = UW'(num_i);
      assign d_in = den_i;
      assign q_in = '0;
    end else begin : g_next
      assign r_in = rem_q[s-1];
      assign d_in = den_q[s-1];
      assign q_in = quo_q[s-1];
    end

    assign d_sh = UW'(d_in) << Bit;

    always_ff @(posedge clk_i) begin
      if (en_i[s]) begin
        den_q[s] <= d_in;
        if (r_in >= d_sh) begin
          rem_q[s] <= r_in - d_sh;
          quo_q[s] <= q_in | (STEPS'(1) << Bit);
        end else begin
          rem_q[s] <= r_in;
          quo_q[s] <= q_in;
        end
      end
    end
  end

  assign quo_o = quo_q[STEPS-1];
  assign rem_o = rem_q[STEPS-1][NUM_W-1:0];
  assign den_o = den_q[STEPS-1];

endmodule

`default_nettype wire

// ===== rtl/core/homography_point_warp.sv =====
`default_nettype none

// Homography point warp. Each input beat on the s_axis channel carries one
// point (pt_x in the low COORD_BITS of tdata, pt_y above it). Each output beat
// on m_axis carries the warped point (out_x low, out_y above) and tuser[0]
// set when the denominator was zero or a coordinate saturated.
// Coefficients are written on the cfg channel (index 0..7 as listed in the
// register map, other indexes are dropped); cfg_ready_o is always high and
// writes are meant to happen while no point is in flight.
// The pipeline is a multiply stage, an add stage, an absolute-value stage, a
// range pre-check, one stage per quotient bit of the restoring divider, a
// rounding stage and the output register. Throughput is one point per cycle
// while the receiver does not stall.
// Every stage holds its own valid bit and advances when the stage after it is
// empty or moving, so a stalled receiver only halts the stages that are full;
// s_axis_tready stays high while the first stage can take a beat.
// Reset empties the pipeline and loads the identity homography.
module homography_point_warp #(
  parameter int unsigned COORD_BITS     = hpw_pkg::COORD_BITS_DEF,
  parameter int unsigned COEF_FRAC_BITS = hpw_pkg::COEF_FRAC_BITS_DEF,
  localparam int unsigned IO_W          = ((2 * COORD_BITS + 7) / 8) * 8
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  input  wire logic [IO_W-1:0]                s_axis_tdata,   // pt_x, pt_y
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  output logic      [IO_W-1:0]                m_axis_tdata,   // out_x, out_y
  output logic      [0:0]                     m_axis_tuser,   // out_of_range
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [hpw_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [hpw_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import hpw_pkg::*;

  localparam int unsigned C       = COORD_BITS;
  localparam int unsigned ALIGN   = PERSP_FRAC_BITS - COEF_FRAC_BITS;
  localparam int unsigned PW      = 32 + C;
  localparam int unsigned NW      = PW + 2 + ALIGN;
  localparam int unsigned STEPS   = C + 1;
  localparam int unsigned UW      = NW + STEPS;
  localparam int unsigned MW      = C + 2;
  localparam int unsigned ST_PROD = 0;
  localparam int unsigned ST_SUM  = 1;
  localparam int unsigned ST_ABS  = 2;
  localparam int unsigned ST_CHK  = 3;
  localparam int unsigned ST_DIV0 = 4;
  localparam int unsigned ST_RND  = ST_DIV0 + STEPS;
  localparam int unsigned ST_OUT  = ST_RND + 1;
  localparam int unsigned NST     = ST_OUT + 1;
  localparam logic [31:0] ONE     = 32'(1) << COEF_FRAC_BITS;
  localparam logic [MW-1:0] LIM   = MW'(1) << (C - 1);
  localparam logic [C-1:0] C_MAX  = {1'b0, {(C-1){1'b1}}};
  localparam logic [C-1:0] C_MIN  = {1'b1, {(C-1){1'b0}}};

  // Configuration registers.
  logic [31:0] h_q [6];
  logic [63:0] persp_q;
  logic [31:0] bias_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_q[0]  <= ONE;
      h_q[1]  <= '0;
      h_q[2]  <= '0;
      h_q[3]  <= '0;
      h_q[4]  <= ONE;
      h_q[5]  <= '0;
      persp_q <= '0;
      bias_q  <= ONE;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_SCALE_XX:   h_q[0]  <= cfg_data_i[31:0];
        REG_SHEAR_XY:   h_q[1]  <= cfg_data_i[31:0];
        REG_SHIFT_X:    h_q[2]  <= cfg_data_i[31:0];
        REG_SHEAR_YX:   h_q[3]  <= cfg_data_i[31:0];
        REG_SCALE_YY:   h_q[4]  <= cfg_data_i[31:0];
        REG_SHIFT_Y:    h_q[5]  <= cfg_data_i[31:0];
        REG_PERSP_PAIR: persp_q <= cfg_data_i;
        REG_PERSP_BIAS: bias_q  <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  // Stage valid bits and per-stage advance enables.
  logic [NST-1:0] v_q;
  logic [NST-1:0] en;

  always_comb begin
    en[NST-1] = !v_q[NST-1] || m_axis_tready;
    for (int k = NST - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= s_axis_tvalid;
      end
      for (int k = 1; k < NST; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  assign s_axis_tready = en[ST_PROD];

  // Multiply stage.
  logic signed [C-1:0]  px, py;
  logic signed [PW-1:0] prod_q [8];

  assign px = $signed(s_axis_tdata[C-1:0]);
  assign py = $signed(s_axis_tdata[2*C-1:C]);

  always_ff @(posedge clk_i) begin
    if (en[ST_PROD]) begin
      prod_q[0] <= $signed(h_q[0]) * px;
      prod_q[1] <= $signed(h_q[1]) * py;
      prod_q[2] <= $signed(h_q[3]) * px;
      prod_q[3] <= $signed(h_q[4]) * py;
      prod_q[4] <= $signed(persp_q[31:0]) * px;
      prod_q[5] <= $signed(persp_q[63:32]) * py;
      prod_q[6] <= PW'($signed(h_q[2]));
      prod_q[7] <= PW'($signed(h_q[5]));
    end
  end

  // Add stage: numerators and denominator on one binary point.
  logic signed [PW+1:0] sum_x, sum_y;
  logic signed [NW-1:0] nx_q, ny_q, dn_q;

  assign sum_x = (PW+2)'(prod_q[0]) + (PW+2)'(prod_q[1]) + (PW+2)'(prod_q[6]);
  assign sum_y = (PW+2)'(prod_q[2]) + (PW+2)'(prod_q[3]) + (PW+2)'(prod_q[7]);

  always_ff @(posedge clk_i) begin
    if (en[ST_SUM]) begin
      nx_q <= NW'(sum_x) <<< ALIGN;
      ny_q <= NW'(sum_y) <<< ALIGN;
      dn_q <= NW'(prod_q[4]) + NW'(prod_q[5]) + (NW'($signed(bias_q)) <<< ALIGN);
    end
  end

  // Absolute-value stage.
  logic [NW-1:0] ax_q, ay_q, ad_q;
  side_t         side_q [ST_ABS:ST_OUT];

  always_ff @(posedge clk_i) begin
    if (en[ST_ABS]) begin
      ax_q <= nx_q[NW-1] ? NW'(-nx_q) : NW'(nx_q);
      ay_q <= ny_q[NW-1] ? NW'(-ny_q) : NW'(ny_q);
      ad_q <= dn_q[NW-1] ? NW'(-dn_q) : NW'(dn_q);
    end
  end

  // Range pre-check: a quotient of 2^(C+1) or more always saturates.
  logic [NW-1:0] cx_q, cy_q, cd_q;
  logic [UW-1:0] d_top;
  side_t         side_chk;

  assign d_top = UW'(ad_q) << STEPS;

  always_comb begin
    side_chk       = side_q[ST_ABS];
    side_chk.ovf_x = UW'(ax_q) >= d_top;
    side_chk.ovf_y = UW'(ay_q) >= d_top;
  end

  always_ff @(posedge clk_i) begin
    if (en[ST_CHK]) begin
      cx_q <= ax_q;
      cy_q <= ay_q;
      cd_q <= ad_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[ST_ABS]) begin
      side_q[ST_ABS] <= '{sn_x: nx_q[NW-1], sn_y: ny_q[NW-1], sd: dn_q[NW-1],
                          dz: (dn_q == '0), zx: (nx_q == '0), zy: (ny_q == '0),
                          ovf_x: 1'b0, ovf_y: 1'b0};
    end
    if (en[ST_CHK]) begin
      side_q[ST_CHK] <= side_chk;
    end
    for (int k = ST_DIV0; k <= ST_OUT; k++) begin
      if (en[k]) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  // Long division of both numerators.
  logic [C:0]    qx, qy;
  logic [NW-1:0] rx, ry, dq, dq_y;

  hpw_divider #(.COORD_BITS(C), .NUM_W(NW)) u_div_x (
    .clk_i (clk_i),
    .en_i  (en[ST_DIV0 +: STEPS]),
    .num_i (cx_q),
    .den_i (cd_q),
    .quo_o (qx),
    .rem_o (rx),
    .den_o (dq)
  );

  hpw_divider #(.COORD_BITS(C), .NUM_W(NW)) u_div_y (
    .clk_i (clk_i),
    .en_i  (en[ST_DIV0 +: STEPS]),
    .num_i (cy_q),
    .den_i (cd_q),
    .quo_o (qy),
    .rem_o (ry),
    .den_o (dq_y)
  );

  // Rounding stage: nearest, ties to even.
  logic [MW-1:0] mx_q, my_q;
  logic          inc_x, inc_y;

  assign inc_x = ({rx, 1'b0} > {1'b0, dq}) || (({rx, 1'b0} == {1'b0, dq}) && qx[0]);
  assign inc_y = ({ry, 1'b0} > {1'b0, dq_y}) || (({ry, 1'b0} == {1'b0, dq_y}) && qy[0]);

  always_ff @(posedge clk_i) begin
    if (en[ST_RND]) begin
      mx_q <= MW'(qx) + MW'(inc_x);
      my_q <= MW'(qy) + MW'(inc_y);
    end
  end

  // Output stage: sign, saturation and the flag.
  logic [C-1:0] ox, oy;
  logic         fx, fy;
  side_t        sr;

  assign sr = side_q[ST_RND];

  always_comb begin
    fx = 1'b0;
    fy = 1'b0;
    if (sr.dz) begin
      fx = 1'b1;
      fy = 1'b1;
      ox = sr.zx ? '0 : (sr.sn_x ? C_MIN : C_MAX);
      oy = sr.zy ? '0 : (sr.sn_y ? C_MIN : C_MAX);
    end else begin
      if (sr.sn_x ^ sr.sd) begin
        fx = sr.ovf_x || (mx_q > LIM);
        ox = fx ? C_MIN : C'(-mx_q);
      end else begin
        fx = sr.ovf_x || (mx_q > LIM - MW'(1));
        ox = fx ? C_MAX : C'(mx_q);
      end
      if (sr.sn_y ^ sr.sd) begin
        fy = sr.ovf_y || (my_q > LIM);
        oy = fy ? C_MIN : C'(-my_q);
      end else begin
        fy = sr.ovf_y || (my_q > LIM - MW'(1));
        oy = fy ? C_MAX : C'(my_q);
      end
    end
  end

  logic [C-1:0] ox_q, oy_q;
  logic         flag_q;

  always_ff @(posedge clk_i) begin
    if (en[ST_OUT]) begin
      ox_q   <= ox;
      oy_q   <= oy;
      flag_q <= fx || fy;
    end
  end

  assign m_axis_tvalid = v_q[ST_OUT];
  assign m_axis_tdata  = IO_W'({oy_q, ox_q});
  assign m_axis_tuser  = flag_q;

  // An empty first stage must always be able to take a beat.
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !v_q[ST_PROD] |-> s_axis_tready)
    else $error("input stalled with an empty first stage");

  // A zero denominator always raises the flag.
  a_zero_den_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && side_q[ST_OUT].dz |-> m_axis_tuser[0])
    else $error("zero denominator without out_of_range");

  // A quotient caught by the range pre-check always saturates.
  a_ovf_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (side_q[ST_OUT].ovf_x || side_q[ST_OUT].ovf_y)
      |-> m_axis_tuser[0])
    else $error("range overflow without out_of_range");

endmodule

`default_nettype wire
